>>> sv/ubxnav_pkg.sv
// Shared types and constants for the UBX navigation frame field extractor.
// Holds sync bytes, message kinds, field codes and the class/id decode.
// Depends on nothing; every other file of the block refers to it by scope.
package ubxnav_pkg;

	// Frame sync bytes
	localparam logic [7:0] SYNC_A = 8'hB5;
	localparam logic [7:0] SYNC_B = 8'h62;

	// Class and id bytes of the recognised messages
	localparam logic [7:0] CLS_NAV     = 8'h01;
	localparam logic [7:0] CLS_SEC     = 8'h27;
	localparam logic [7:0] ID_PVT      = 8'h07;
	localparam logic [7:0] ID_POSLLH   = 8'h02;
	localparam logic [7:0] ID_TIMEUTC  = 8'h21;
	localparam logic [7:0] ID_UNIQID   = 8'h03;
	localparam logic [7:0] ID_SAT      = 8'h35;

	// Message kinds
	localparam logic [2:0] KIND_PVT     = 3'd0;
	localparam logic [2:0] KIND_POSLLH  = 3'd1;
	localparam logic [2:0] KIND_TIMEUTC = 3'd2;
	localparam logic [2:0] KIND_UNIQID  = 3'd3;
	localparam logic [2:0] KIND_SAT     = 3'd4;
	localparam logic [2:0] KIND_NONE    = 3'd7;

	// Field codes
	localparam logic [4:0] FC_YEAR     = 5'd0;
	localparam logic [4:0] FC_MONTH    = 5'd1;
	localparam logic [4:0] FC_FIX      = 5'd7;
	localparam logic [4:0] FC_SATS     = 5'd8;
	localparam logic [4:0] FC_LON      = 5'd9;
	localparam logic [4:0] FC_UNIQID   = 5'd22;
	localparam logic [4:0] FC_SATCOUNT = 5'd23;

	localparam int unsigned VALUE_W = 40;

	// Result of the field table lookup for one frame offset
	typedef struct packed {
		logic       hit;
		logic [4:0] code;
		logic [2:0] k;
		logic       done;
		logic       last;
	} field_hit_t;

	// One result item
	typedef struct packed {
		logic [2:0]         kind;
		logic [VALUE_W-1:0] value;
		logic [4:0]         code;
		logic               last;
	} result_t;

	// Map the latched class and id bytes onto a message kind
	function automatic logic [2:0] kind_of(input logic [7:0] cls, input logic [7:0] id);
		logic [2:0] kind;
		kind = KIND_NONE;
		if (cls == CLS_SEC && id == ID_UNIQID) begin
			kind = KIND_UNIQID;
		end else if (cls == CLS_NAV) begin
			if (id == ID_PVT) begin
				kind = KIND_PVT;
			end else if (id == ID_POSLLH) begin
				kind = KIND_POSLLH;
			end else if (id == ID_TIMEUTC) begin
				kind = KIND_TIMEUTC;
			end else if (id == ID_SAT) begin
				kind = KIND_SAT;
			end
		end
		return kind;
	endfunction

endpackage

>>> sv/ubxnav_field_lut.sv
// Field layout table: for a message kind and a frame offset it gives the
// field code, the byte index within the field and whether the field ends.
// Depends on ubxnav_pkg.
module ubxnav_field_lut (
	input  logic [2:0]              kind,
	input  logic [6:0]              offset,
	output ubxnav_pkg::field_hit_t  field
);

	logic [6:0] rel;

	// Decode the offset against the fixed layout of each message
	always_comb begin
		field = '0;
		rel   = '0;
		case (kind)
			ubxnav_pkg::KIND_PVT: begin
				if (offset inside {[7'd10:7'd11]}) begin
					field.hit  = 1'b1;
					field.code = ubxnav_pkg::FC_YEAR;
					field.k    = 3'(offset - 7'd10);
					field.done = (offset == 7'd11);
				end else if (offset inside {[7'd12:7'd17]}) begin
					rel        = offset - 7'd12;
					field.hit  = 1'b1;
					field.code = 5'(ubxnav_pkg::FC_MONTH + rel[4:0]);
					field.done = 1'b1;
				end else if (offset == 7'd26) begin
					field.hit  = 1'b1;
					field.code = ubxnav_pkg::FC_FIX;
					field.done = 1'b1;
				end else if (offset == 7'd29) begin
					field.hit  = 1'b1;
					field.code = ubxnav_pkg::FC_SATS;
					field.done = 1'b1;
				end else if (offset inside {[7'd30:7'd81]}) begin
					// Run of 4-byte fields from longitude to heading accuracy
					rel        = offset - 7'd30;
					field.hit  = 1'b1;
					field.code = 5'(ubxnav_pkg::FC_LON + rel[6:2]);
					field.k    = {1'b0, rel[1:0]};
					field.done = (rel[1:0] == 2'd3);
					field.last = (offset == 7'd81);
				end
			end
			ubxnav_pkg::KIND_POSLLH: begin
				if (offset inside {[7'd10:7'd33]}) begin
					rel        = offset - 7'd10;
					field.hit  = 1'b1;
					field.code = 5'(ubxnav_pkg::FC_LON + rel[6:2]);
					field.k    = {1'b0, rel[1:0]};
					field.done = (rel[1:0] == 2'd3);
					field.last = (offset == 7'd33);
				end
			end
			ubxnav_pkg::KIND_TIMEUTC: begin
				if (offset inside {[7'd18:7'd19]}) begin
					field.hit  = 1'b1;
					field.code = ubxnav_pkg::FC_YEAR;
					field.k    = 3'(offset - 7'd18);
					field.done = (offset == 7'd19);
				end else if (offset inside {[7'd20:7'd24]}) begin
					rel        = offset - 7'd20;
					field.hit  = 1'b1;
					field.code = 5'(ubxnav_pkg::FC_MONTH + rel[4:0]);
					field.done = 1'b1;
					field.last = (offset == 7'd24);
				end
			end
			ubxnav_pkg::KIND_UNIQID: begin
				if (offset inside {[7'd10:7'd14]}) begin
					field.hit  = 1'b1;
					field.code = ubxnav_pkg::FC_UNIQID;
					field.k    = 3'(offset - 7'd10);
					field.done = (offset == 7'd14);
					field.last = (offset == 7'd14);
				end
			end
			ubxnav_pkg::KIND_SAT: begin
				if (offset == 7'd11) begin
					field.hit  = 1'b1;
					field.code = ubxnav_pkg::FC_SATCOUNT;
					field.done = 1'b1;
					field.last = 1'b1;
				end
			end
			default: begin
				field = '0;
			end
		endcase
	end

endmodule

>>> sv/ubxnav_out_skid.sv
// Output register with a skid stage for result items.
// The upstream side keeps being accepted while one result waits downstream.
// Depends on ubxnav_pkg.
module ubxnav_out_skid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ubxnav_pkg::result_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ubxnav_pkg::result_t  out_data
);

	logic                 out_valid_q;
	logic                 skid_valid_q;
	ubxnav_pkg::result_t  out_data_q;
	ubxnav_pkg::result_t  skid_data_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Control flags of the two stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= in_valid;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload of the two stages
	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_valid && !skid_valid_q) begin
			skid_data_q <= in_data;
		end
	end

endmodule

>>> sv/ubx_nav_frame_field_extractor.sv
// Top level of the UBX navigation frame field extractor: sync hunting,
// frame offset tracking, field assembly and the result output stage.
// Depends on ubxnav_pkg, ubxnav_field_lut and ubxnav_out_skid.
//
//  channel  | direction | tdata (low bit up)                     | tuser / tlast
//  ---------+-----------+----------------------------------------+--------------------
//  s_*      | in        | rx_byte[7:0]                           | - / -
//  m_*      | out       | field_code[4:0], field_value[44:5]     | message_kind[2:0] /
//           |           |                                        | last_in_message
//
// The sync, offset and assembly registers are updated at the edge that
// accepts a received byte, and a completed field lands in the output
// register, or in the skid register while the output stalls, at that same edge.
// A byte is accepted every cycle while the skid stage is empty, so one
// stalled result does not hold the input back.
// Reset returns to hunting for the first sync byte and empties the output.
module ubx_nav_frame_field_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // field_code[4:0], field_value[44:5], zeros[47:45]
	output logic [2:0]  m_tuser,   // message_kind[2:0]
	output logic        m_tlast    // last_in_message
);

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_SYNC1 = 2'd1,
		PH_FRAME = 2'd2
	} phase_t;

	phase_t                         phase_q, phase_n;
	logic [6:0]                     offset_q, offset_n;
	logic [7:0]                     class_q, class_n;
	logic [7:0]                     id_q, id_n;
	logic [ubxnav_pkg::VALUE_W-1:0] asm_q, asm_n;

	logic                           accept;
	logic                           emit;
	logic [2:0]                     kind;
	ubxnav_pkg::field_hit_t         field;
	ubxnav_pkg::result_t            result;
	ubxnav_pkg::result_t            out_item;
	logic [ubxnav_pkg::VALUE_W-1:0] byte_shifted;

	assign accept = s_tvalid && s_tready;
	assign kind   = ubxnav_pkg::kind_of(class_q, id_q);

	ubxnav_field_lut u_lut (
		.kind   (kind),
		.offset (offset_q),
		.field  (field)
	);

	// Place the received byte at its position within the field
	assign byte_shifted = {{(ubxnav_pkg::VALUE_W-8){1'b0}}, s_tdata} << {field.k, 3'b000};

	// Next state for one received byte
	always_comb begin
		phase_n  = phase_q;
		offset_n = offset_q;
		class_n  = class_q;
		id_n     = id_q;
		asm_n    = asm_q;
		emit     = 1'b0;
		case (phase_q)
			PH_SYNC1: begin
				if (s_tdata == ubxnav_pkg::SYNC_B) begin
					phase_n  = PH_FRAME;
					offset_n = 7'd2;
				end else if (s_tdata != ubxnav_pkg::SYNC_A) begin
					phase_n  = PH_HUNT;
					offset_n = '0;
				end
			end
			PH_FRAME: begin
				offset_n = offset_q + 7'd1;
				if (offset_q == 7'd2) begin
					class_n = s_tdata;
				end else if (offset_q == 7'd3) begin
					id_n = s_tdata;
					if (ubxnav_pkg::kind_of(class_q, s_tdata) == ubxnav_pkg::KIND_NONE) begin
						phase_n  = PH_HUNT;
						offset_n = '0;
					end
				end else if (kind == ubxnav_pkg::KIND_NONE) begin
					phase_n  = PH_HUNT;
					offset_n = '0;
				end else if (field.hit) begin
					asm_n = ((field.k == 3'd0) ? '0 : asm_q) | byte_shifted;
					if (field.done) begin
						emit = 1'b1;
						if (field.last) begin
							phase_n  = PH_HUNT;
							offset_n = '0;
						end
					end
				end
			end
			default: begin
				// Hunting, and the unused phase code, which behaves the same
				if (s_tdata == ubxnav_pkg::SYNC_A) begin
					phase_n  = PH_SYNC1;
					offset_n = 7'd1;
				end else begin
					phase_n  = PH_HUNT;
					offset_n = '0;
				end
			end
		endcase
	end

	// Frame tracking and assembly registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			offset_q <= '0;
			class_q  <= '0;
			id_q     <= '0;
			asm_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_n;
			offset_q <= offset_n;
			class_q  <= class_n;
			id_q     <= id_n;
			asm_q    <= asm_n;
		end
	end

	// Result item for a completed field
	always_comb begin
		result.kind  = kind;
		result.value = asm_n;
		result.code  = field.code;
		result.last  = field.last;
	end

	ubxnav_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept && emit),
		.in_ready  (s_tready),
		.in_data   (result),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_item)
	);

	assign m_tdata = {3'b000, out_item.value, out_item.code};
	assign m_tuser = out_item.kind;
	assign m_tlast = out_item.last;

endmodule
